### rtl/ers_pkg.sv
// shared constants, types and helper functions for the elevator request scheduler
package ers_pkg;

  // building size and derived button count
  localparam int FLOORS     = 4;
  localparam int NBUTTONS   = 3 * FLOORS - 2;
  localparam int LAST_FLOOR = FLOORS - 1;

  // beat field widths
  localparam int FLOOR_W   = 2;
  localparam int DIR_W     = 2;
  localparam int BUTTON_W  = 10;

  // motor direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef logic [FLOOR_W-1:0]  floor_t;
  typedef logic [NBUTTONS-1:0] flags_t;

  // button classes
  typedef enum logic [1:0] {
    BTN_CAB  = 2'd0,
    BTN_UP   = 2'd1,
    BTN_DOWN = 2'd2
  } btn_class_t;

  // floor served by a button index
  function automatic floor_t floor_of(input int i);
    int f;
    begin
      if (i < FLOORS) begin
        f = i;
      end else if (i < 2 * FLOORS - 1) begin
        f = i - FLOORS;
      end else begin
        f = i - (2 * FLOORS - 1) + 1;
      end
      return floor_t'(f);
    end
  endfunction

  // class of a button index
  function automatic btn_class_t class_of(input int i);
    begin
      if (i < FLOORS) begin
        return BTN_CAB;
      end else if (i < 2 * FLOORS - 1) begin
        return BTN_UP;
      end else begin
        return BTN_DOWN;
      end
    end
  endfunction

endpackage

### rtl/ers_req_if.sv
// request channel: floor, direction, pressed buttons and clear flags
interface ers_req_if;
  logic                          valid;
  logic                          ready;
  logic [ers_pkg::FLOOR_W-1:0]   car_floor;
  logic [ers_pkg::DIR_W-1:0]     travel_direction;
  logic [ers_pkg::BUTTON_W-1:0]  pressed_buttons;
  logic                          clear_floor;
  logic                          clear_all;

  modport source (
    output valid, car_floor, travel_direction, pressed_buttons, clear_floor, clear_all,
    input  ready
  );
  modport sink (
    input  valid, car_floor, travel_direction, pressed_buttons, clear_floor, clear_all,
    output ready
  );
endinterface

### rtl/ers_res_if.sv
// result channel: direction, stop decision and request summary
interface ers_res_if;
  logic                          valid;
  logic                          ready;
  logic [ers_pkg::DIR_W-1:0]     next_direction;
  logic                          stop_here;
  logic                          floor_has_request;
  logic [ers_pkg::FLOOR_W-1:0]   first_active_floor;
  logic                          any_request;

  modport source (
    output valid, next_direction, stop_here, floor_has_request, first_active_floor,
           any_request,
    input  ready
  );
  modport sink (
    input  valid, next_direction, stop_here, floor_has_request, first_active_floor,
           any_request,
    output ready
  );
endinterface

### rtl/elevator_request_scheduler_unit.sv
// Elevator request scheduler: input register, request table, decision logic, result register
// A request beat is captured in the input register and its result in the result register;
// the result beat is then held on res until it is taken.
// Throughput: one beat per cycle unless res stalls; the request table is read and updated
// once per beat in the decision stage, so each beat sees the clears of the one before.
// Reset (rst, synchronous, active high) clears the request table and both valid flags.
module elevator_request_scheduler_unit (
  input  logic      clk,
  input  logic      rst,
  ers_req_if.sink   req,
  ers_res_if.source res
);

  // input register
  logic                          s1_valid;
  logic [ers_pkg::FLOOR_W-1:0]   s1_floor;
  logic [ers_pkg::DIR_W-1:0]     s1_dir;
  logic [ers_pkg::BUTTON_W-1:0]  s1_pressed;
  logic                          s1_clr_floor;
  logic                          s1_clr_all;

  // request table
  ers_pkg::flags_t               request_flags;
  ers_pkg::flags_t               request_flags_next;

  // result register
  logic                          out_valid;
  ers_pkg::dir_t                 out_dir;
  logic                          out_stop;
  logic                          out_here;
  ers_pkg::floor_t               out_first;
  logic                          out_any;

  // decision stage signals
  logic                          advance;
  ers_pkg::floor_t               fl;
  ers_pkg::dir_t                 dir;
  ers_pkg::flags_t               merged;
  ers_pkg::flags_t               here_mask;
  logic                          above;
  logic                          below;
  logic                          here;
  logic                          cab;
  logic                          upc;
  logic                          dnc;
  logic                          farthest;
  logic                          stop;
  ers_pkg::dir_t                 nd;
  ers_pkg::floor_t               first;

  // handshake: decision stage moves when the result register is free or draining
  assign advance   = s1_valid && (!out_valid || res.ready);
  assign req.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_floor     <= req.car_floor;
      s1_dir       <= req.travel_direction;
      s1_pressed   <= req.pressed_buttons;
      s1_clr_floor <= req.clear_floor;
      s1_clr_all   <= req.clear_all;
    end
  end

  // floor saturation and direction decode
  always_comb begin
    if (int'(s1_floor) > ers_pkg::LAST_FLOOR) begin
      fl = ers_pkg::floor_t'(ers_pkg::LAST_FLOOR);
    end else begin
      fl = s1_floor;
    end
    case (s1_dir)
      ers_pkg::DIR_UP:   dir = ers_pkg::DIR_UP;
      ers_pkg::DIR_DOWN: dir = ers_pkg::DIR_DOWN;
      default:           dir = ers_pkg::DIR_STOP;
    endcase
  end

  // merge pressed buttons and classify active requests against the car floor
  always_comb begin
    merged    = request_flags | ers_pkg::flags_t'(s1_pressed);
    here_mask = '0;
    above     = 1'b0;
    below     = 1'b0;
    here      = 1'b0;
    cab       = 1'b0;
    upc       = 1'b0;
    dnc       = 1'b0;
    for (int i = 0; i < ers_pkg::NBUTTONS; i++) begin
      if (ers_pkg::floor_of(i) == fl) begin
        here_mask[i] = 1'b1;
      end
      if (merged[i]) begin
        if (ers_pkg::floor_of(i) > fl) begin
          above = 1'b1;
        end else if (ers_pkg::floor_of(i) < fl) begin
          below = 1'b1;
        end else begin
          here = 1'b1;
          case (ers_pkg::class_of(i))
            ers_pkg::BTN_CAB: cab = 1'b1;
            ers_pkg::BTN_UP:  upc = 1'b1;
            default:          dnc = 1'b1;
          endcase
        end
      end
    end
  end

  // lowest-index active button, scanned from the top so the lowest wins
  always_comb begin
    first = '0;
    for (int i = ers_pkg::NBUTTONS - 1; i >= 0; i--) begin
      if (merged[i]) begin
        first = ers_pkg::floor_of(i);
      end
    end
  end

  // next direction: keep going while requests lie ahead, else reverse, else stop; an idle car prefers up
  always_comb begin
    if (dir == ers_pkg::DIR_DOWN) begin
      nd = below ? ers_pkg::DIR_DOWN : (above ? ers_pkg::DIR_UP : ers_pkg::DIR_STOP);
    end else begin
      nd = above ? ers_pkg::DIR_UP : (below ? ers_pkg::DIR_DOWN : ers_pkg::DIR_STOP);
    end
  end

  // stop rule: end floors always, else cab, same-direction call or farthest request
  always_comb begin
    case (dir)
      ers_pkg::DIR_UP:   farthest = !above;
      ers_pkg::DIR_DOWN: farthest = !below;
      default:           farthest = 1'b1;
    endcase
    if (fl == '0 || fl == ers_pkg::floor_t'(ers_pkg::LAST_FLOOR)) begin
      stop = 1'b1;
    end else begin
      stop = here && (farthest || cab || (upc && dir == ers_pkg::DIR_UP) ||
                      (dnc && dir == ers_pkg::DIR_DOWN));
    end
  end

  // table update after the results
  always_comb begin
    if (s1_clr_all) begin
      request_flags_next = '0;
    end else if (s1_clr_floor) begin
      request_flags_next = merged & ~here_mask;
    end else begin
      request_flags_next = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_flags <= '0;
    end else if (advance) begin
      request_flags <= request_flags_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_dir   <= nd;
      out_stop  <= stop;
      out_here  <= here;
      out_first <= first;
      out_any   <= |merged;
    end
  end

  assign res.valid              = out_valid;
  assign res.next_direction     = out_dir;
  assign res.stop_here          = out_stop;
  assign res.floor_has_request  = out_here;
  assign res.first_active_floor = out_first;
  assign res.any_request        = out_any;

endmodule
